/* hdl/tpag_pkg.sv */
// Shared types and constants for the tensor permute address generator.
package tpag_pkg;

  // Fixed field widths of the transaction payloads.
  localparam int MODE_W     = 2;
  localparam int SLOT_W     = 4;
  localparam int SIZE_W     = 16;
  localparam int STRIDE_W   = 32;
  localparam int PERM_W     = 5;
  localparam int OFS_W      = 32;
  localparam int ERR_W      = 2;
  localparam int RANK_W     = 5;
  localparam int SLOT_COUNT = 16;

  // Configuration port layout.
  localparam int                CFG_ADDR_W    = 2;
  localparam int                CFG_DATA_W    = 32;
  localparam [CFG_ADDR_W-1:0]   REG_RANK_ADDR = 2'd0;
  localparam [RANK_W-1:0]       RANK_RESET    = 5'd1;

  // Input transaction kinds.
  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_DIM  = 2'd0,
    MODE_LOAD_PERM = 2'd1,
    MODE_START     = 2'd2,
    MODE_ADVANCE   = 2'd3
  } mode_t;

  // Result error codes.
  typedef enum logic [ERR_W-1:0] {
    ERR_OK          = 2'd0,
    ERR_RANGE       = 2'd1,
    ERR_DUP         = 2'd2,
    ERR_NOT_STARTED = 2'd3
  } err_t;

  // Start sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CHECK = 2'd1,
    ST_FILL  = 2'd2,
    ST_REPLY = 2'd3
  } state_t;

  // Per-dimension data shifted along the cell row during a start.
  typedef struct packed {
    logic [SIZE_W-1:0]   size_m1;
    logic [STRIDE_W-1:0] step_add;
  } cell_load_t;

  // Row-wide strobes.
  typedef struct packed {
    logic shift;
    logic advance;
  } cell_ctl_t;

endpackage

/* hdl/tpag_cell.sv */
// One dimension cell: size, step increment and mixed-radix counter digit.
module tpag_cell
  import tpag_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cell_ctl_t           ctl,
  input  logic                active,
  input  logic                carry_in,
  input  cell_load_t          load_in,
  output cell_load_t          load_out,
  output logic                carry_out,
  output logic                inc,
  output logic [OFS_W-1:0]    add_out
);

  logic [SIZE_W-1:0]   size_m1_r;
  logic [STRIDE_W-1:0] step_add_r;
  logic [SIZE_W-1:0]   count_r;
  logic [SIZE_W-1:0]   count_nxt;
  logic                at_max_r;
  logic                at_max_nxt;
  logic                eff_max;
  logic [SIZE_W-1:0]   count_inc;

  // An unused cell always looks wrapped so the carry passes through it.
  assign eff_max   = at_max_r | ~active;
  assign carry_out = carry_in & eff_max;
  assign inc       = carry_in & ~eff_max;
  assign add_out   = inc ? step_add_r : '0;
  assign load_out  = '{size_m1: size_m1_r, step_add: step_add_r};
  assign count_inc = count_r + 1'b1;

  // Counter digit: cleared on load, stepped or wrapped on an advance carry.
  always_comb begin
    count_nxt  = count_r;
    at_max_nxt = at_max_r;
    if (ctl.shift) begin
      count_nxt  = '0;
      at_max_nxt = (load_in.size_m1 == '0);
    end else if (ctl.advance && carry_in && active) begin
      if (at_max_r) begin
        count_nxt  = '0;
        at_max_nxt = (size_m1_r == '0);
      end else begin
        count_nxt  = count_inc;
        at_max_nxt = (count_inc == size_m1_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      at_max_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      at_max_r <= at_max_nxt;
    end
  end

  // Dimension data moves one cell up the row on each shift.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      size_m1_r  <= load_in.size_m1;
      step_add_r <= load_in.step_add;
    end
  end

endmodule

/* hdl/tpag_chain.sv */
// Row of dimension cells with the carry chain and step increment selection.
module tpag_chain
  import tpag_pkg::*;
#(
  parameter int NUM_CELLS = 16
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_ctl_t            ctl,
  input  logic [NUM_CELLS-1:0] active,
  input  cell_load_t           feed,
  output logic [OFS_W-1:0]     step_sum,
  output logic                 step_any,
  output logic                 all_max
);

  cell_load_t             load_out [NUM_CELLS];
  logic [NUM_CELLS-1:0]   carry_out;
  logic [NUM_CELLS-1:0]   inc;
  logic [OFS_W-1:0]       add_out  [NUM_CELLS];

  // Cell 0 takes the feed; the last cell is the fastest digit.
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    cell_load_t load_in;
    logic       carry_in;

    if (i == 0) begin : g_head
      assign load_in = feed;
    end else begin : g_body
      assign load_in = load_out[i-1];
    end

    if (i == NUM_CELLS - 1) begin : g_fast
      assign carry_in = 1'b1;
    end else begin : g_slow
      assign carry_in = carry_out[i+1];
    end

    tpag_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .active    (active[i]),
      .carry_in  (carry_in),
      .load_in   (load_in),
      .load_out  (load_out[i]),
      .carry_out (carry_out[i]),
      .inc       (inc[i]),
      .add_out   (add_out[i])
    );
  end

  // At most one cell increments; its masked increment is merged by OR.
  always_comb begin
    step_sum = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      step_sum = step_sum | add_out[i];
    end
  end

  assign step_any = |inc;
  assign all_max  = carry_out[0];

endmodule

/* hdl/tensor_permute_address_generator_top.sv */
// Top level: register port, source stores, start sequencer and result register.
//
//  Channel  Direction  Handshake              Payload
//  in       input      in_valid / in_ready    in_mode, in_slot, in_dim_size,
//                                             in_dim_stride, in_perm_dim
//  out      output     out_valid / out_ready  out_source_offset, out_last, out_error
//  cfg      input      psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// Load and advance transactions may follow back to back.
// A start first checks each permutation entry, then shifts the derived sizes and
// step increments through the cell row, then posts the result; a failed check
// goes straight to posting the result.
// rst_n is synchronous; it clears the sequencer, counters, offset and rank to 1.
// A held result in the output register blocks new input only while out_ready is low.
module tensor_permute_address_generator_top
  import tpag_pkg::*;
#(
  parameter int MAX_DIMS = 16
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [SLOT_W-1:0]     in_slot,
  input  logic [SIZE_W-1:0]     in_dim_size,
  input  logic [STRIDE_W-1:0]   in_dim_stride,
  input  logic signed [PERM_W-1:0] in_perm_dim,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OFS_W-1:0]      out_source_offset,
  output logic                  out_last,
  output logic [ERR_W-1:0]      out_error
);

  localparam int          DIM_W    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam [RANK_W-1:0] MAX_RANK = RANK_W'(MAX_DIMS);

  // Configuration and sequencer state.
  logic [RANK_W-1:0]   rank_r;
  logic [RANK_W-1:0]   live_rank;
  logic                prepared_r;
  state_t              state_r;
  state_t              state_nxt;
  err_t                err_r;
  logic [RANK_W-1:0]   cnt_r;
  logic [MAX_DIMS-1:0] seen_r;
  logic                issue_r;

  // Source stores and the checked permutation.
  logic [SIZE_W-1:0]   src_size_mem   [SLOT_COUNT];
  logic [STRIDE_W-1:0] src_stride_mem [SLOT_COUNT];
  logic [PERM_W-1:0]   perm_mem       [SLOT_COUNT];
  logic [SLOT_W-1:0]   src_mem        [MAX_DIMS];

  // Fill pipeline and running offset.
  logic                pa_valid_r;
  logic                pa_last_r;
  logic [SIZE_W-1:0]   pa_size_m1_r;
  logic [STRIDE_W-1:0] pa_stride_r;
  logic [STRIDE_W-1:0] pa_prod_r;
  logic [STRIDE_W-1:0] acc_r;
  logic [OFS_W-1:0]    offset_r;

  // Result register.
  logic                out_valid_r;
  logic [OFS_W-1:0]    out_offset_r;
  logic                out_last_r;
  logic [ERR_W-1:0]    out_error_r;

  logic                cfg_write;
  logic                out_free;
  logic                in_fire;
  mode_t               in_mode_e;
  logic                result_now;
  logic                advance_go;
  logic                check_en;
  logic                fill_en;
  logic                reply_en;
  logic                idle_st;

  logic signed [PERM_W-1:0] perm_val;
  logic signed [PERM_W:0]   perm_abs;
  logic                range_bad;
  logic                dup_bad;
  logic                check_last;

  logic [SLOT_W-1:0]   fill_src;
  logic [SIZE_W-1:0]   fill_size;
  logic [SIZE_W-1:0]   fill_eff;
  logic [SIZE_W+STRIDE_W-1:0] fill_prod;

  logic [MAX_DIMS-1:0] active;
  cell_ctl_t           ctl;
  cell_load_t          feed;
  logic [OFS_W-1:0]    step_sum;
  logic                step_any;
  logic                all_max;

  // Register port.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready & (paddr == REG_RANK_ADDR);
  assign prdata    = (paddr == REG_RANK_ADDR) ? CFG_DATA_W'(rank_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= RANK_RESET;
    end else if (cfg_write) begin
      rank_r <= pwdata[RANK_W-1:0];
    end
  end

  // Rank in use: zero acts as one, anything above the row length is clipped.
  always_comb begin
    if (rank_r == '0) begin
      live_rank = RANK_W'(1);
    end else if (rank_r > MAX_RANK) begin
      live_rank = MAX_RANK;
    end else begin
      live_rank = rank_r;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_DIMS; i++) begin
      active[i] = (RANK_W'(i) < live_rank);
    end
  end

  // Handshake helpers.
  assign out_free   = ~out_valid_r | out_ready;
  assign in_mode_e  = mode_t'(in_mode);
  assign in_fire    = in_valid & in_ready;
  assign result_now = in_fire & (in_mode_e != MODE_START);
  assign advance_go = in_fire & (in_mode_e == MODE_ADVANCE) & prepared_r;

  // Permutation check for the entry at cnt_r.
  assign perm_val   = perm_mem[cnt_r[SLOT_W-1:0]];
  assign perm_abs   = PERM_W'(0) + {perm_val[PERM_W-1], perm_val}
                    + (perm_val[PERM_W-1] ? $signed({1'b0, live_rank}) : '0);
  assign range_bad  = perm_abs[PERM_W] | (perm_abs[PERM_W-1:0] >= live_rank);
  assign dup_bad    = ~range_bad & seen_r[perm_abs[DIM_W-1:0]];
  assign check_last = (cnt_r == live_rank - 1'b1);

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_mode_e == MODE_START)) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (range_bad || dup_bad) begin
          state_nxt = ST_REPLY;
        end else if (check_last) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (pa_valid_r && pa_last_r) begin
          state_nxt = ST_REPLY;
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    idle_st  = 1'b0;
    check_en = 1'b0;
    fill_en  = 1'b0;
    reply_en = 1'b0;
    case (state_r)
      ST_IDLE:  idle_st  = 1'b1;
      ST_CHECK: check_en = 1'b1;
      ST_FILL:  fill_en  = 1'b1;
      ST_REPLY: reply_en = out_free;
      default:  idle_st  = 1'b0;
    endcase
  end

  assign in_ready = idle_st & out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Load transactions write the source stores.
  always_ff @(posedge clk) begin
    if (in_fire && (in_mode_e == MODE_LOAD_DIM)) begin
      src_size_mem[in_slot]   <= in_dim_size;
      src_stride_mem[in_slot] <= in_dim_stride;
    end
    if (in_fire && (in_mode_e == MODE_LOAD_PERM)) begin
      perm_mem[in_slot] <= in_perm_dim;
    end
  end

  // Check walks entries upward; fill then walks them downward.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      seen_r  <= '0;
      issue_r <= 1'b0;
      err_r   <= ERR_OK;
    end else if (in_fire && (in_mode_e == MODE_START)) begin
      cnt_r   <= '0;
      seen_r  <= '0;
      issue_r <= 1'b0;
      err_r   <= ERR_OK;
    end else if (check_en) begin
      if (range_bad) begin
        err_r <= ERR_RANGE;
      end else if (dup_bad) begin
        err_r <= ERR_DUP;
      end else begin
        seen_r[perm_abs[DIM_W-1:0]] <= 1'b1;
        if (check_last) begin
          issue_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end else if (fill_en && issue_r) begin
      if (cnt_r == '0) begin
        issue_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Checked source dimension of each output position.
  always_ff @(posedge clk) begin
    if (check_en && !range_bad && !dup_bad) begin
      src_mem[cnt_r[DIM_W-1:0]] <= SLOT_W'(perm_abs[PERM_W-1:0]);
    end
  end

  // Fill stage one: fetch size and stride, form size times stride.
  assign fill_src  = src_mem[cnt_r[DIM_W-1:0]];
  assign fill_size = src_size_mem[fill_src];
  assign fill_eff  = (fill_size == '0) ? SIZE_W'(1) : fill_size;
  assign fill_prod = src_stride_mem[fill_src] * fill_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_valid_r <= 1'b0;
      pa_last_r  <= 1'b0;
    end else begin
      pa_valid_r <= fill_en & issue_r;
      pa_last_r  <= (cnt_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (fill_en && issue_r) begin
      pa_size_m1_r <= fill_eff - 1'b1;
      pa_stride_r  <= src_stride_mem[fill_src];
      pa_prod_r    <= fill_prod[STRIDE_W-1:0];
    end
  end

  // Fill stage two: step increment is the stride plus the wrap-back of all
  // faster dimensions, which accumulate as entries arrive fastest first.
  assign feed = '{size_m1: pa_size_m1_r, step_add: pa_stride_r + acc_r};

  always_ff @(posedge clk) begin
    if (check_en) begin
      acc_r <= '0;
    end else if (pa_valid_r) begin
      acc_r <= acc_r + pa_stride_r - pa_prod_r;
    end
  end

  assign ctl = '{shift: pa_valid_r, advance: advance_go};

  tpag_chain #(
    .NUM_CELLS (MAX_DIMS)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .active   (active),
    .feed     (feed),
    .step_sum (step_sum),
    .step_any (step_any),
    .all_max  (all_max)
  );

  // Running offset: add the selected increment, or return to zero on full wrap or at the end of a fill.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else if (advance_go) begin
      offset_r <= step_any ? (offset_r + step_sum) : '0;
    end else if (pa_valid_r && pa_last_r) begin
      offset_r <= '0;
    end
  end

  // Prepared flag: set by a clean start, cleared by a failed one or a rank write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prepared_r <= 1'b0;
    end else if (cfg_write) begin
      prepared_r <= 1'b0;
    end else if (check_en && (range_bad || dup_bad)) begin
      prepared_r <= 1'b0;
    end else if (pa_valid_r && pa_last_r) begin
      prepared_r <= 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (result_now || reply_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (reply_en) begin
      out_offset_r <= '0;
      out_last_r   <= 1'b0;
      out_error_r  <= err_r;
    end else if (result_now) begin
      if (in_mode_e == MODE_ADVANCE) begin
        if (prepared_r) begin
          out_offset_r <= offset_r;
          out_last_r   <= all_max;
          out_error_r  <= ERR_OK;
        end else begin
          out_offset_r <= '0;
          out_last_r   <= 1'b0;
          out_error_r  <= ERR_NOT_STARTED;
        end
      end else begin
        out_offset_r <= '0;
        out_last_r   <= 1'b0;
        out_error_r  <= ERR_OK;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_source_offset = out_offset_r;
  assign out_last          = out_last_r;
  assign out_error         = out_error_r;

endmodule

/* dv/tb_tensor_permute_address_generator_top.sv */
// Self-checking testbench for the tensor permute address generator top level.
`timescale 1ns / 1ps

module tb_tensor_permute_address_generator_top;
  import tpag_pkg::*;

  localparam int DIRECTED_ITEMS = 25;
  localparam int RANDOM_ITEMS   = 1650;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int TAIL_CYCLES    = 60;

  // One input transaction and one result transaction.
  typedef struct {
    mode_t                    mode;
    logic [SLOT_W-1:0]        slot;
    logic [SIZE_W-1:0]        size;
    logic [STRIDE_W-1:0]      stride;
    logic signed [PERM_W-1:0] perm;
  } walk_item_t;

  typedef struct {
    logic [OFS_W-1:0] ofs;
    logic             last;
    err_t             err;
  } walk_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]    paddr = '0;
  logic [CFG_DATA_W-1:0]    pwdata = '0;
  logic [CFG_DATA_W-1:0]    prdata;
  logic                     pready;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [MODE_W-1:0]        in_mode = '0;
  logic [SLOT_W-1:0]        in_slot = '0;
  logic [SIZE_W-1:0]        in_dim_size = '0;
  logic [STRIDE_W-1:0]      in_dim_stride = '0;
  logic signed [PERM_W-1:0] in_perm_dim = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [OFS_W-1:0]         out_source_offset;
  logic                     out_last;
  logic [ERR_W-1:0]         out_error;

  tensor_permute_address_generator_top #(.MAX_DIMS(16)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_mode(in_mode),
    .in_slot(in_slot),
    .in_dim_size(in_dim_size),
    .in_dim_stride(in_dim_stride),
    .in_perm_dim(in_perm_dim),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_source_offset(out_source_offset),
    .out_last(out_last),
    .out_error(out_error)
  );

  // Stimulus and expectation stores.
  walk_item_t   items_to_send[$];
  walk_result_t offsets_due[$];
  walk_item_t   on_pins;
  int           items_queued = 0;
  int           items_taken = 0;
  int           mismatch_count = 0;
  int           results_seen = 0;
  int           cycle_count = 0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  logic [15:0]  dim_written = '0;
  logic [15:0]  perm_written = '0;

  // Predictor state, kept in step with the block.
  logic [RANK_W-1:0]        rank_reg = RANK_RESET;
  logic [SIZE_W-1:0]        src_size[SLOT_COUNT];
  logic [STRIDE_W-1:0]      src_stride[SLOT_COUNT];
  logic signed [PERM_W-1:0] perm_tab[SLOT_COUNT];
  logic [SIZE_W-1:0]        walk_size[SLOT_COUNT];
  logic [STRIDE_W-1:0]      walk_stride[SLOT_COUNT];
  logic [SIZE_W-1:0]        walk_ctr[SLOT_COUNT];
  logic [OFS_W-1:0]         walk_ofs = '0;
  bit                       walk_armed = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Rank as the block uses it: zero acts as one, anything above 16 as 16.
  function automatic int live_rank();
    int r;
    r = rank_reg;
    if (r == 0) r = 1;
    if (r > SLOT_COUNT) r = SLOT_COUNT;
    return r;
  endfunction

  function automatic logic [31:0] live_size(logic [SIZE_W-1:0] s);
    return (s == '0) ? 32'd1 : 32'(s);
  endfunction

  // Validate the permutation and derive the walk tables.
  function automatic err_t start_walk();
    int r;
    int v;
    int src[SLOT_COUNT];
    logic [SLOT_COUNT-1:0] seen;
    r = live_rank();
    seen = '0;
    for (int i = 0; i < r; i++) begin
      v = perm_tab[i];
      if (v < 0) v += r;
      if (v < 0 || v >= r) begin
        walk_armed = 1'b0;
        return ERR_RANGE;
      end
      if (seen[v]) begin
        walk_armed = 1'b0;
        return ERR_DUP;
      end
      seen[v] = 1'b1;
      src[i] = v;
    end
    for (int i = 0; i < r; i++) begin
      walk_size[i]   = src_size[src[i]];
      walk_stride[i] = src_stride[src[i]];
    end
    for (int i = 0; i < SLOT_COUNT; i++) walk_ctr[i] = '0;
    walk_ofs = '0;
    walk_armed = 1'b1;
    return ERR_OK;
  endfunction

  // Mixed-radix step, last dimension fastest; offsets wrap at 32 bits.
  function automatic void step_walk();
    int i;
    logic [31:0] sz;
    logic [31:0] nxt;
    logic [31:0] back;
    i = live_rank();
    while (i > 0) begin
      i--;
      sz = live_size(walk_size[i]);
      nxt = 32'(walk_ctr[i]) + 32'd1;
      walk_ofs = walk_ofs + walk_stride[i];
      if (nxt >= sz) begin
        back = sz * walk_stride[i];
        walk_ofs = walk_ofs - back;
        walk_ctr[i] = '0;
      end else begin
        walk_ctr[i] = nxt[SIZE_W-1:0];
        return;
      end
    end
  endfunction

  // Expected result of one accepted transaction.
  function automatic walk_result_t predict_offset(walk_item_t it);
    walk_result_t res;
    int r;
    res.ofs = '0;
    res.last = 1'b0;
    res.err = ERR_OK;
    case (it.mode)
      MODE_LOAD_DIM: begin
        src_size[it.slot] = it.size;
        src_stride[it.slot] = it.stride;
      end
      MODE_LOAD_PERM: perm_tab[it.slot] = it.perm;
      MODE_START: res.err = start_walk();
      default: begin
        if (!walk_armed) begin
          res.err = ERR_NOT_STARTED;
        end else begin
          r = live_rank();
          res.ofs = walk_ofs;
          res.last = 1'b1;
          for (int i = 0; i < r; i++) begin
            if (32'(walk_ctr[i]) != live_size(walk_size[i]) - 32'd1) res.last = 1'b0;
          end
          step_walk();
        end
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("[%0t] result %0d: %s", $time, results_seen, msg);
  endtask

  // Driver: presents queued transactions, with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        offsets_due.push_back(predict_offset(on_pins));
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (items_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          on_pins = items_to_send.pop_front();
          in_valid      <= 1'b1;
          in_mode       <= on_pins.mode;
          in_slot       <= on_pins.slot;
          in_dim_size   <= on_pins.size;
          in_dim_stride <= on_pins.stride;
          in_perm_dim   <= on_pins.perm;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Monitor: checks each result transaction against the oldest expectation.
  always @(posedge clk) begin
    walk_result_t due;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (offsets_due.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        due = offsets_due.pop_front();
        if (out_source_offset !== due.ofs)
          report_mismatch($sformatf("source_offset %h, expected %h", out_source_offset, due.ofs));
        if (out_last !== due.last)
          report_mismatch($sformatf("last %b, expected %b", out_last, due.last));
        if (out_error !== due.err)
          report_mismatch($sformatf("error %0d, expected %0d", out_error, due.err));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic void queue_item(mode_t m, logic [SLOT_W-1:0] s, logic [SIZE_W-1:0] z,
                                     logic [STRIDE_W-1:0] d, logic signed [PERM_W-1:0] p);
    walk_item_t it;
    it.mode = m;
    it.slot = s;
    it.size = z;
    it.stride = d;
    it.perm = p;
    if (m == MODE_LOAD_DIM) dim_written[s] = 1'b1;
    if (m == MODE_LOAD_PERM) perm_written[s] = 1'b1;
    items_to_send.push_back(it);
    items_queued++;
  endfunction

  // A start or advance whose unused fields carry random values.
  function automatic void queue_bare(mode_t m);
    queue_item(m, SLOT_W'($urandom), SIZE_W'($urandom), $urandom, PERM_W'($urandom));
  endfunction

  function automatic logic [STRIDE_W-1:0] pick_stride();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return $urandom;
      default: return $urandom_range(1, 4096);
    endcase
  endfunction

  // Sizes mostly small so that walks reach the end; now and then a huge one.
  function automatic logic [SIZE_W-1:0] pick_walk_size(inout int span, inout bit huge);
    int k;
    k = $urandom_range(0, 23);
    if (k == 0) begin
      huge = 1'b1;
      return '1;
    end
    if (k == 1) begin
      huge = 1'b1;
      return SIZE_W'($urandom_range(70, 65534));
    end
    if (k < 4) return '0;
    if (k < 14) return 16'd1;
    k = $urandom_range(2, 5);
    if (span * k > 64) return 16'd1;
    span = span * k;
    return SIZE_W'(k);
  endfunction

  // A start must never read an entry that was never loaded.
  function automatic void fill_unwritten();
    int r;
    r = live_rank();
    for (int i = 0; i < r; i++) begin
      if (!dim_written[i])
        queue_item(MODE_LOAD_DIM, SLOT_W'(i), SIZE_W'($urandom), $urandom, '0);
      if (!perm_written[i])
        queue_item(MODE_LOAD_PERM, SLOT_W'(i), '0, '0, PERM_W'($urandom));
    end
  endfunction

  // Walk: load dims and a permutation, start, then advance; small walks reach the end or pass it.
  function automatic void queue_walk();
    int r;
    int span;
    int n;
    int j;
    int k;
    int v;
    int tmp;
    bit huge;
    int order[SLOT_COUNT];
    logic signed [PERM_W-1:0] code[SLOT_COUNT];
    r = live_rank();
    span = 1;
    huge = 1'b0;
    for (int i = 0; i < r; i++)
      queue_item(MODE_LOAD_DIM, SLOT_W'(i), pick_walk_size(span, huge), pick_stride(), '0);
    for (int i = 0; i < SLOT_COUNT; i++) order[i] = i;
    for (int i = r - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < r; i++)
      code[i] = $urandom_range(0, 1) ? PERM_W'(order[i] - r) : PERM_W'(order[i]);
    // Occasionally break the permutation with a duplicate or an out-of-range entry.
    if ($urandom_range(0, 4) == 0) begin
      j = $urandom_range(0, r - 1);
      if (r == SLOT_COUNT || (r > 1 && $urandom_range(0, 1) == 1)) begin
        k = (j + $urandom_range(1, r - 1)) % r;
        code[j] = code[k];
      end else begin
        if ($urandom_range(0, 1) == 1) v = $urandom_range(r, 15);
        else v = 0 - int'($urandom_range(r + 1, 16));
        code[j] = PERM_W'(v);
      end
    end
    for (int i = 0; i < r; i++) queue_item(MODE_LOAD_PERM, SLOT_W'(i), '0, '0, code[i]);
    queue_bare(MODE_START);
    n = huge ? $urandom_range(3, 24) : span + $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        if ($urandom_range(0, 1) == 1)
          queue_item(MODE_LOAD_DIM, SLOT_W'($urandom), SIZE_W'($urandom), $urandom, '0);
        else
          queue_item(MODE_LOAD_PERM, SLOT_W'($urandom), '0, '0, PERM_W'($urandom));
      end
      queue_bare(MODE_ADVANCE);
    end
  endfunction

  // Stray transactions: lone advances, random loads and starts on whatever is loaded.
  function automatic void queue_noise();
    case ($urandom_range(0, 3))
      0: queue_bare(MODE_ADVANCE);
      1: queue_item(MODE_LOAD_DIM, SLOT_W'($urandom), SIZE_W'($urandom), $urandom,
                    PERM_W'($urandom));
      2: queue_item(MODE_LOAD_PERM, SLOT_W'($urandom), SIZE_W'($urandom), $urandom,
                    PERM_W'($urandom));
      default: begin
        fill_unwritten();
        queue_bare(MODE_START);
      end
    endcase
  endfunction

  task automatic wait_idle();
    while (items_to_send.size() != 0 || items_taken != items_queued || offsets_due.size() != 0)
      @(negedge clk);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_rank(logic [RANK_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_RANK_ADDR;
    pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    rank_reg = value;
    walk_armed = 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int phase;
    int stop_at;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at rank 3: not-started advance, field extremes, every start error.
    write_rank(5'd3);
    queue_bare(MODE_ADVANCE);
    queue_item(MODE_LOAD_DIM, 4'd0, 16'hFFFF, 32'd1, '0);
    queue_item(MODE_LOAD_DIM, 4'd1, 16'h0000, 32'hFFFF_FFFF, '0);
    queue_item(MODE_LOAD_DIM, 4'd2, 16'd2, 32'h0000_0100, '0);
    queue_item(MODE_LOAD_DIM, 4'd15, 16'd1, 32'h0, '0);
    queue_item(MODE_LOAD_PERM, 4'd0, '0, '0, -5'sd1);
    queue_item(MODE_LOAD_PERM, 4'd1, '0, '0, 5'sd0);
    queue_item(MODE_LOAD_PERM, 4'd2, '0, '0, 5'sd3);
    queue_bare(MODE_START);
    queue_bare(MODE_ADVANCE);
    queue_item(MODE_LOAD_PERM, 4'd2, '0, '0, -5'sd16);
    queue_bare(MODE_START);
    queue_item(MODE_LOAD_PERM, 4'd2, '0, '0, 5'sd15);
    queue_bare(MODE_START);
    queue_item(MODE_LOAD_PERM, 4'd2, '0, '0, -5'sd3);
    queue_bare(MODE_START);
    queue_item(MODE_LOAD_PERM, 4'd2, '0, '0, 5'sd1);
    queue_bare(MODE_START);
    repeat (4) queue_bare(MODE_ADVANCE);
    // A load in the middle of a walk must not disturb it.
    queue_item(MODE_LOAD_DIM, 4'd0, 16'd7, 32'd9, '0);
    repeat (2) queue_bare(MODE_ADVANCE);

    // Random phases, each with its own rank and idle pattern.
    phase = 0;
    while (items_queued < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      wait_idle();
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 56; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 56; end
        default: begin send_idle_pct = 21; stall_pct = 21; end
      endcase
      case (phase)
        0: write_rank(5'd16);
        1: write_rank(5'd1);
        2: write_rank(5'd0);
        3: write_rank(5'd31);
        default: write_rank(RANK_W'($urandom_range(1, 16)));
      endcase
      // The rank write has just cleared the armed walk.
      queue_bare(MODE_ADVANCE);
      stop_at = items_queued + 80;
      while (items_queued < stop_at) begin
        if ($urandom_range(0, 5) == 0) queue_noise();
        else queue_walk();
      end
      // Let the sender hold off until the block has drained.
      if (phase % 3 == 1) wait_idle();
      stop_at = items_queued + 80;
      while (items_queued < stop_at) begin
        if ($urandom_range(0, 5) == 0) queue_noise();
        else queue_walk();
      end
      phase++;
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && offsets_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
